// File: hw/rtl/urc_pkg.sv
package urc_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int VAL_W     = 32;
    localparam int RANK_W    = 6;

    // request queue between front and back
    localparam int Q_DEPTH   = 2;
    localparam int PTR_W     = $clog2(Q_DEPTH);
    localparam int QCNT_W    = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_TEXT = 2'd1,
        ST_DUP  = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    // request as handed from the front classifier to the back sequencer
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             bad;
        logic             last;
    } q_entry_t;

endpackage

// File: hw/rtl/urc_ram.sv
module urc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/urc_front.sv
module urc_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [63:0] s_value,
    input  logic               s_format_ok,
    input  logic               s_last,
    output logic               q_valid,
    output urc_pkg::q_entry_t  q_item,
    input  logic               q_pop
);
    import urc_pkg::*;

    q_entry_t            entry_reg [Q_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                push;
    logic                in_range;
    q_entry_t            new_entry;

    // fits in int32 when bits 63..31 are all equal
    assign in_range = (s_value[63:31] == '0) || (s_value[63:31] == '1);

    always_comb begin
        new_entry.value = s_value[VAL_W-1:0];
        new_entry.bad   = !s_format_ok || !in_range;
        new_entry.last  = s_last;
    end

    assign s_ready = (cnt_reg != QCNT_W'(Q_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && q_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

// File: hw/rtl/urc_back.sv
module urc_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  urc_pkg::q_entry_t              q_item,
    output logic                           q_pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [urc_pkg::RANK_W-1:0]     m_rank,
    output logic [1:0]                     m_status,
    output logic                           m_final_res
);
    import urc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DUP,
        S_RLOAD,
        S_RKEY,
        S_RSCAN,
        S_ROUT,
        S_EOUT
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    status_t             err_reg, err_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic                pend_reg, pend_next;
    logic                dup_reg, dup_next;
    logic [VAL_W-1:0]    cur_val_reg, cur_val_next;
    logic                cur_last_reg, cur_last_next;
    logic [IDX_W-1:0]    i_reg, i_next;
    logic [VAL_W-1:0]    key_reg, key_next;
    logic [RANK_W-1:0]   acc_reg, acc_next;
    logic                m_valid_reg, m_valid_next;
    logic [RANK_W-1:0]   m_rank_reg, m_rank_next;
    status_t             m_status_reg, m_status_next;
    logic                m_final_reg, m_final_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_raddr;
    logic [VAL_W-1:0]    ram_rdata;
    status_t             err_dec;
    logic                is_less;
    logic                is_final;

    urc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (cur_val_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // signed order via sign-flipped unsigned compare
    assign is_less  = ({~ram_rdata[VAL_W-1], ram_rdata[VAL_W-2:0]}
                       < {~key_reg[VAL_W-1], key_reg[VAL_W-2:0]});
    assign is_final = (CNT_W'(i_reg) + 1'b1 == count_reg);

    always_comb begin
        if (dup_reg) begin
            err_dec = ST_DUP;
        end else if (count_reg == CNT_W'(MAX_ITEMS)) begin
            err_dec = ST_FULL;
        end else begin
            err_dec = ST_OK;
        end
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        err_next      = err_reg;
        scan_next     = scan_reg;
        pend_next     = 1'b0;
        dup_next      = dup_reg;
        cur_val_next  = cur_val_reg;
        cur_last_next = cur_last_reg;
        i_next        = i_reg;
        key_next      = key_reg;
        acc_next      = acc_reg;
        m_valid_next  = m_valid_reg;
        m_rank_next   = m_rank_reg;
        m_status_next = m_status_reg;
        m_final_next  = m_final_reg;
        q_pop         = 1'b0;
        ram_we        = 1'b0;
        ram_raddr     = scan_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop         = 1'b1;
                    cur_val_next  = q_item.value;
                    cur_last_next = q_item.last;
                    if (err_reg != ST_OK || q_item.bad) begin
                        // run already failed, or this element fails the text/range check
                        if (err_reg == ST_OK) begin
                            err_next = ST_TEXT;
                        end
                        if (q_item.last) begin
                            m_valid_next  = 1'b1;
                            m_rank_next   = '0;
                            m_status_next = (err_reg == ST_OK) ? ST_TEXT : err_reg;
                            m_final_next  = 1'b1;
                            state_next    = S_EOUT;
                        end
                    end else begin
                        scan_next  = '0;
                        dup_next   = 1'b0;
                        state_next = S_DUP;
                    end
                end
            end
            S_DUP: begin
                if (pend_reg && ram_rdata == cur_val_reg) begin
                    dup_next = 1'b1;
                end
                if (scan_reg < count_reg) begin
                    scan_next = scan_reg + 1'b1;
                    pend_next = 1'b1;
                end else if (!pend_reg) begin
                    err_next = err_dec;
                    if (err_dec == ST_OK) begin
                        ram_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (!cur_last_reg) begin
                        state_next = S_IDLE;
                    end else if (err_dec != ST_OK) begin
                        m_valid_next  = 1'b1;
                        m_rank_next   = '0;
                        m_status_next = err_dec;
                        m_final_next  = 1'b1;
                        state_next    = S_EOUT;
                    end else begin
                        i_next     = '0;
                        state_next = S_RLOAD;
                    end
                end
            end
            S_RLOAD: begin
                ram_raddr  = i_reg;
                state_next = S_RKEY;
            end
            S_RKEY: begin
                key_next   = ram_rdata;
                scan_next  = '0;
                acc_next   = '0;
                state_next = S_RSCAN;
            end
            S_RSCAN: begin
                if (pend_reg && is_less) begin
                    acc_next = acc_reg + 1'b1;
                end
                if (scan_reg < count_reg) begin
                    scan_next = scan_reg + 1'b1;
                    pend_next = 1'b1;
                end else if (!pend_reg) begin
                    m_valid_next  = 1'b1;
                    m_rank_next   = acc_reg;
                    m_status_next = ST_OK;
                    m_final_next  = is_final;
                    state_next    = S_ROUT;
                end
            end
            S_ROUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_final_reg) begin
                        count_next = '0;
                        err_next   = ST_OK;
                        state_next = S_IDLE;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_RLOAD;
                    end
                end
            end
            S_EOUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    count_next   = '0;
                    err_next     = ST_OK;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            err_reg     <= ST_OK;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            err_reg     <= err_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        scan_reg     <= scan_next;
        dup_reg      <= dup_next;
        cur_val_reg  <= cur_val_next;
        cur_last_reg <= cur_last_next;
        i_reg        <= i_next;
        key_reg      <= key_next;
        acc_reg      <= acc_next;
        m_rank_reg   <= m_rank_next;
        m_status_reg <= m_status_next;
        m_final_reg  <= m_final_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_rank      = m_rank_reg;
    assign m_status    = m_status_reg;
    assign m_final_res = m_final_reg;

endmodule

// File: hw/rtl/unique_rank_compressor.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+------------------------------------
// input    | s_valid / s_ready  | s_value[63:0], s_format_ok, s_last
// result   | m_valid / m_ready  | m_rank[5:0], m_status[1:0], m_final_res
//
// A loaded element is popped, then checked against the stored elements at
// one store read per cycle for the duplicate scan, then a read-latency
// wait and a decision follow. Ranking after the last element pauses on
// output stalls: one comparator walks every pair through the single store
// read port.
// A two-entry request queue lets the input run ahead while the back end
// scans or a result waits. Reset (aresetn low, synchronous) empties the
// queue and clears the run; store contents are not cleared.
module unique_rank_compressor (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [63:0]          s_value,
    input  logic                        s_format_ok,
    input  logic                        s_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [urc_pkg::RANK_W-1:0]  m_rank,
    output logic [1:0]                  m_status,
    output logic                        m_final_res
);
    import urc_pkg::*;

    logic     q_valid;
    logic     q_pop;
    q_entry_t q_item;

    urc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .s_format_ok (s_format_ok),
        .s_last      (s_last),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    urc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rank      (m_rank),
        .m_status    (m_status),
        .m_final_res (m_final_res)
    );

    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_err_is_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_final_res && m_rank == '0))
        else $error("error result not a lone final result");

    a_pop_pauses_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !q_pop)
        else $error("request taken while result pending");

endmodule

// File: tb/unique_rank_compressor_checker.sv
`timescale 1ns / 100ps

module unique_rank_compressor_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic signed [63:0]          s_value,
    input  logic                        s_format_ok,
    input  logic                        s_last,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [urc_pkg::RANK_W-1:0]  m_rank,
    input  logic [1:0]                  m_status,
    input  logic                        m_final_res,
    output int unsigned                 pending,
    output int unsigned                 fail_count
);
    import urc_pkg::*;

    localparam logic signed [63:0] INT32_HI = 64'sd2147483647;
    localparam logic signed [63:0] INT32_LO = -64'sd2147483648;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        status_t           status;
        logic              final_res;
    } rank_result_t;

    rank_result_t      expected_ranks[$];
    logic [VAL_W-1:0]  list_store [MAX_ITEMS];
    int unsigned       list_len = 0;
    status_t           list_fault = ST_OK;
    int unsigned       n_fail = 0;

    function automatic void note_failure(input string what);
        n_fail++;
        if (n_fail <= 10) begin
            $display("%0t: mismatch: %s", $time, what);
        end
    endfunction

    // one accepted request: update the list state, queue the ranks (or the error result) at end of list
    task automatic load_element(input logic signed [63:0] v, input logic fmt,
                                input logic lst);
        logic [VAL_W-1:0] w;
        logic             dup;
        int unsigned      smaller;
        if (list_fault == ST_OK) begin
            if (!fmt || v > INT32_HI || v < INT32_LO) begin
                list_fault = ST_TEXT;
            end else begin
                w   = v[VAL_W-1:0];
                dup = 1'b0;
                for (int i = 0; i < list_len; i++) begin
                    if (list_store[i] == w) dup = 1'b1;
                end
                if (dup) begin
                    list_fault = ST_DUP;
                end else if (list_len >= MAX_ITEMS) begin
                    list_fault = ST_FULL;
                end else begin
                    list_store[list_len] = w;
                    list_len++;
                end
            end
        end
        if (lst) begin
            if (list_fault != ST_OK) begin
                expected_ranks.push_back(rank_result_t'{rank: '0, status: list_fault,
                                                         final_res: 1'b1});
            end else begin
                for (int i = 0; i < list_len; i++) begin
                    smaller = 0;
                    for (int j = 0; j < list_len; j++) begin
                        if ($signed(list_store[j]) < $signed(list_store[i])) smaller++;
                    end
                    expected_ranks.push_back(rank_result_t'{
                        rank: smaller[RANK_W-1:0], status: ST_OK,
                        final_res: (i == list_len - 1)});
                end
            end
            list_len   = 0;
            list_fault = ST_OK;
        end
    endtask

    always @(posedge aclk) begin
        rank_result_t exp_r;
        if (aresetn) begin
            // results first: a request accepted now cannot produce a result this edge
            if (m_valid && m_ready) begin
                if (expected_ranks.size() == 0) begin
                    note_failure($sformatf("unexpected result rank=%0d status=%0d final=%0b",
                                           m_rank, m_status, m_final_res));
                end else begin
                    exp_r = expected_ranks.pop_front();
                    if (m_rank !== exp_r.rank || m_status !== exp_r.status ||
                        m_final_res !== exp_r.final_res) begin
                        note_failure($sformatf(
                            "rank %0d/%0d status %0d/%0d final %0b/%0b (exp/act)",
                            exp_r.rank, m_rank, exp_r.status, m_status,
                            exp_r.final_res, m_final_res));
                    end
                end
            end
            if (s_valid && s_ready) begin
                load_element(s_value, s_format_ok, s_last);
            end
        end
        pending    <= expected_ranks.size();
        fail_count <= n_fail;
    end

endmodule

// File: tb/unique_rank_compressor_tb.sv
`timescale 1ns / 100ps

module unique_rank_compressor_tb;
    import urc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned RANDOM_ITEMS = 260;
    localparam int unsigned TAIL_CYCLES  = 200;

    localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] I32_MIN = -64'sd2147483648;

    typedef enum int {F_NONE, F_DUP, F_TEXT, F_RANGE, F_FULL} fault_t;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic signed [63:0]  s_value     = '0;
    logic                s_format_ok = 1'b0;
    logic                s_last      = 1'b0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic [RANK_W-1:0]   m_rank;
    logic [1:0]          m_status;
    logic                m_final_res;

    int unsigned pending;
    int unsigned fail_count;
    int unsigned cycle_cnt    = 0;
    int unsigned results_seen = 0;
    int unsigned error_seen   = 0;
    int unsigned n_sent       = 0;
    int unsigned n_lists      = 0;
    int unsigned burst_left   = 0;

    logic signed [63:0] list_vals[$];

    always #4 aclk = ~aclk;

    unique_rank_compressor dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .s_format_ok (s_format_ok),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rank      (m_rank),
        .m_status    (m_status),
        .m_final_res (m_final_res)
    );

    unique_rank_compressor_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .s_format_ok (s_format_ok),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rank      (m_rank),
        .m_status    (m_status),
        .m_final_res (m_final_res),
        .pending     (pending),
        .fail_count  (fail_count)
    );

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (m_status != ST_OK) error_seen <= error_seen + 1;
        end
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
            $display("** unique_rank_compressor: FAILED **");
            $finish;
        end
    end

    // receiver: one long hold-off mid-run, otherwise shifting stall patterns
    initial begin : receiver
        int unsigned mode;
        int unsigned mode_left;
        logic        held;
        mode      = 0;
        mode_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held && results_seen >= 30 && m_valid) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 4) == 0);
                    default: m_ready <= (mode_left % 7) < 3;
                endcase
            end
        end
    end

    function automatic logic signed [63:0] rand_in_range();
        logic signed [31:0] w;
        case ($urandom_range(0, 3))
            0: w = $urandom_range(0, 15) - 8;
            1: begin
                case ($urandom_range(0, 5))
                    0:       w = I32_MIN[31:0];
                    1:       w = I32_MIN[31:0] + 1;
                    2:       w = I32_MAX[31:0];
                    3:       w = I32_MAX[31:0] - 1;
                    4:       w = '0;
                    default: w = '1;
                endcase
            end
            default: w = $urandom;
        endcase
        return {{32{w[31]}}, w};
    endfunction

    // anything whose upper half is not the sign extension of the lower half
    function automatic logic signed [63:0] wide_value();
        logic [31:0] hi;
        logic [31:0] lo;
        hi = $urandom;
        lo = $urandom;
        if (hi == {32{lo[31]}}) hi = ~hi;
        return {hi, lo};
    endfunction

    function automatic logic is_listed(input logic signed [63:0] v);
        foreach (list_vals[i]) begin
            if (list_vals[i] == v) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic signed [63:0] fresh_value();
        logic signed [63:0] v;
        v = rand_in_range();
        while (is_listed(v)) v = rand_in_range();
        return v;
    endfunction

    task automatic send_req(input logic signed [63:0] v, input logic fmt, input logic lst);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid     <= 1'b1;
        s_value     <= v;
        s_format_ok <= fmt;
        s_last      <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        n_sent++;
        if (lst) n_lists++;
    endtask

    // stop offering requests until every queued result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic send_list(input int unsigned len, input int unsigned fault_at,
                             input fault_t fault);
        logic signed [63:0] v;
        logic               fmt;
        for (int i = 0; i < len; i++) begin
            fmt = 1'b1;
            if (fault == F_NONE || i < fault_at) begin
                v = fresh_value();
            end else if (i == fault_at) begin
                case (fault)
                    F_DUP:   v = list_vals[$urandom_range(0, list_vals.size() - 1)];
                    F_TEXT: begin
                        fmt = 1'b0;
                        case ($urandom_range(0, 2))
                            0:       v = fresh_value();
                            1:       v = wide_value();
                            default: v = (list_vals.size() != 0)
                                       ? list_vals[$urandom_range(0, list_vals.size() - 1)]
                                       : fresh_value();
                        endcase
                    end
                    F_RANGE: v = wide_value();
                    default: v = fresh_value();
                endcase
            end else begin
                // after the fault: arbitrary junk, ignored by the block
                v   = ($urandom_range(0, 3) == 0) ? wide_value() : rand_in_range();
                fmt = ($urandom_range(0, 3) != 0);
            end
            list_vals.push_back(v);
            send_req(v, fmt, i == len - 1);
        end
        list_vals.delete();
    endtask

    initial begin : stimulus
        int unsigned random_start;
        int unsigned len;
        int unsigned pick;
        logic        mid_drained;
        fault_t      fault;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed lists
        send_req(I32_MAX, 1'b1, 1'b1);
        send_req(64'sd0, 1'b1, 1'b0);
        send_req(I32_MIN, 1'b1, 1'b0);
        send_req(-64'sd1, 1'b1, 1'b0);
        send_req(I32_MAX, 1'b1, 1'b0);
        send_req(64'sd1, 1'b1, 1'b1);
        send_req(I32_MAX + 1, 1'b1, 1'b1);
        send_req(I32_MIN - 1, 1'b1, 1'b1);
        send_req(64'sh7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
        send_req(64'sh8000_0000_0000_0000, 1'b1, 1'b1);
        // duplicate with bad text: text error wins
        send_req(64'sd3, 1'b1, 1'b0);
        send_req(64'sd3, 1'b0, 1'b1);
        send_req(-64'sd5, 1'b1, 1'b0);
        send_req(64'sd9, 1'b1, 1'b0);
        send_req(-64'sd5, 1'b1, 1'b1);
        // requests after an error are not checked
        send_req(64'sd1, 1'b1, 1'b0);
        send_req(64'sd2, 1'b0, 1'b0);
        send_req(64'sd2, 1'b1, 1'b0);
        send_req(I32_MAX + 7, 1'b1, 1'b1);
        send_req(I32_MIN, 1'b1, 1'b0);
        send_req(I32_MIN + 1, 1'b1, 1'b1);
        drain_results();

        random_start = n_sent;
        mid_drained  = 1'b0;

        // full store, then one past full; receiver hold-off lands here
        send_list(MAX_ITEMS, 0, F_NONE);
        send_list(MAX_ITEMS + 1 + $urandom_range(0, 2), MAX_ITEMS,
                  fault_t'($urandom_range(F_DUP, F_FULL)));

        while (n_sent - random_start < RANDOM_ITEMS) begin
            len  = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 24);
            pick = $urandom_range(0, 9);
            if (pick == 6 && len >= 2) fault = F_DUP;
            else if (pick == 7)        fault = F_TEXT;
            else if (pick == 8)        fault = F_RANGE;
            else                       fault = F_NONE;
            send_list(len, $urandom_range((fault == F_DUP) ? 1 : 0, len - 1), fault);
            if (!mid_drained && n_sent - random_start > 180) begin
                mid_drained = 1'b1;
                drain_results();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d lists, %0d requests, %0d results (%0d error results),",
                 n_lists, n_sent, results_seen, error_seen);
        $display("including full-store lists, overflow, a long result hold-off and drains.");
        if (fail_count == 0) begin
            $display("** unique_rank_compressor: PASSED **");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("** unique_rank_compressor: FAILED **");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/urc_pkg.sv
hw/rtl/urc_ram.sv
hw/rtl/urc_front.sv
hw/rtl/urc_back.sv
hw/rtl/unique_rank_compressor.sv
tb/unique_rank_compressor_checker.sv
tb/unique_rank_compressor_tb.sv
